>>> hw/rtl/rme_pkg.sv
package rme_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    // Vector datapath: Q2.14 inputs scaled to Q6.28, giving headroom for the CORDIC gain.
    localparam int XW = 34;
    // Angle datapath: radians with 24 fraction bits.
    localparam int ZW = 28;
    localparam int ANG_FRAC = 24;
    localparam int LIMIT_W = 15;
    localparam int MAG_W = 32;
    localparam int GAIN_W = 30;

    localparam logic signed [ZW-1:0] HALF_PI_A = ZW'(26353589);
    localparam logic [GAIN_W-1:0] GAIN_INV_Q30 = GAIN_W'(652032874);
    localparam logic signed [17:0] PI_Q13 = 18'sd25736;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        r = '0;
        unique case (i)
            0: r = ZW'(13176795);
            1: r = ZW'(7778716);
            2: r = ZW'(4110060);
            3: r = ZW'(2086331);
            4: r = ZW'(1047214);
            5: r = ZW'(524117);
            6: r = ZW'(262123);
            7: r = ZW'(131069);
            default: begin
                if (i <= ANG_FRAC) begin
                    r = ZW'(64'sd1 <<< (ANG_FRAC - i));
                end else begin
                    r = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [XW-1:0] widen(input logic signed [15:0] v);
        return {{(XW-30){v[15]}}, v, 14'b0};
    endfunction

    function automatic logic [15:0] to_q13(input logic signed [ZW-1:0] z);
        logic signed [ZW:0] s;
        logic signed [17:0] r;
        s = {z[ZW-1], z} + (ZW+1)'(1024);
        r = 18'(s >>> (ANG_FRAC - 13));
        if (r > PI_Q13) begin
            r = PI_Q13;
        end else if (r < -PI_Q13) begin
            r = -PI_Q13;
        end
        return r[15:0];
    endfunction

endpackage

>>> hw/rtl/rme_cordic_cell.sv
module rme_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  rme_pkg::cordic_t  in_d,
    output rme_pkg::cordic_t  out_q
);

    rme_pkg::cordic_t cell_reg;
    rme_pkg::cordic_t cell_next;

    always_comb begin
        cell_next = in_d;
        // Turn towards the x axis: clockwise while y is non-negative.
        if (!in_d.y[rme_pkg::XW-1]) begin
            cell_next.x = in_d.x + (in_d.y >>> SHIFT);
            cell_next.y = in_d.y - (in_d.x >>> SHIFT);
            cell_next.z = in_d.z + rme_pkg::atan_entry(SHIFT);
        end else begin
            cell_next.x = in_d.x - (in_d.y >>> SHIFT);
            cell_next.y = in_d.y + (in_d.x >>> SHIFT);
            cell_next.z = in_d.z - rme_pkg::atan_entry(SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_q = cell_reg;

endmodule

>>> hw/rtl/rme_cordic_chain.sv
module rme_cordic_chain #(
    parameter int STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [rme_pkg::XW-1:0] x_in,
    input  logic signed [rme_pkg::XW-1:0] y_in,
    output rme_pkg::cordic_t              out_q
);

    rme_pkg::cordic_t pre_reg;
    rme_pkg::cordic_t pre_next;
    rme_pkg::cordic_t stage_w [STAGES+1];

    // Left half-plane vectors are first turned by a quarter turn.
    always_comb begin
        pre_next.x    = x_in;
        pre_next.y    = y_in;
        pre_next.z    = '0;
        pre_next.zero = (x_in == '0) && (y_in == '0);
        if (x_in[rme_pkg::XW-1]) begin
            if (!y_in[rme_pkg::XW-1]) begin
                pre_next.x = y_in;
                pre_next.y = -x_in;
                pre_next.z = rme_pkg::HALF_PI_A;
            end else begin
                pre_next.x = -y_in;
                pre_next.y = x_in;
                pre_next.z = -rme_pkg::HALF_PI_A;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pre_reg <= pre_next;
        end
    end

    assign stage_w[0] = pre_reg;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        rme_cordic_cell #(.SHIFT(i)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .in_d  (stage_w[i]),
            .out_q (stage_w[i+1])
        );
    end

    assign out_q = stage_w[STAGES];

endmodule

>>> hw/rtl/rotation_matrix_to_euler.sv
// Pipeline from an accepted request to its result: two CORDIC chains in series of
// CORDIC_STAGES + 1 registers each, one multiplier register, one output register. Throughput:
// one matrix per cycle while the pipeline advances, set by the fully pipelined CORDIC cells.
// The whole pipeline advances whenever the output register is empty or being taken.
// Synchronous active-low reset clears the valid bits and sets singular_limit to 1.
module rotation_matrix_to_euler #(
    parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rme_pkg::LIMIT_W-1:0]     cfg_singular_limit,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [15:0]              s_r00,
    input  logic signed [15:0]              s_r10,
    input  logic signed [15:0]              s_r11,
    input  logic signed [15:0]              s_r12,
    input  logic signed [15:0]              s_r20,
    input  logic signed [15:0]              s_r21,
    input  logic signed [15:0]              s_r22,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [15:0]              m_roll_angle,
    output logic signed [15:0]              m_pitch_angle,
    output logic signed [15:0]              m_yaw_angle,
    output logic                            m_singular
);

    localparam int L = CORDIC_STAGES + 1;
    localparam int D = 2 * L + 2;
    localparam int XW = rme_pkg::XW;
    localparam int ZW = rme_pkg::ZW;
    localparam int MW = rme_pkg::MAG_W;
    localparam int PW = MW + rme_pkg::GAIN_W;

    logic en;
    logic [D-1:0] valid_reg;
    logic [rme_pkg::LIMIT_W-1:0] limit_reg;

    assign en        = m_ready || !valid_reg[D-1];
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = valid_reg[D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            limit_reg <= rme_pkg::LIMIT_W'(1);
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[D-2:0], s_valid};
            end
            if (cfg_valid) begin
                limit_reg <= cfg_singular_limit;
            end
        end
    end

    // First rank: yaw, gimbal-lock yaw and roll vectors in parallel.
    rme_pkg::cordic_t yaw_c, alt_c, roll_c, pitch_c;

    rme_cordic_chain #(.STAGES(CORDIC_STAGES)) u_yaw (
        .aclk (aclk), .en (en),
        .x_in (rme_pkg::widen(s_r00)), .y_in (rme_pkg::widen(s_r10)),
        .out_q (yaw_c)
    );

    rme_cordic_chain #(.STAGES(CORDIC_STAGES)) u_alt (
        .aclk (aclk), .en (en),
        .x_in (rme_pkg::widen(s_r11)), .y_in (-rme_pkg::widen(s_r12)),
        .out_q (alt_c)
    );

    rme_cordic_chain #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk (aclk), .en (en),
        .x_in (rme_pkg::widen(s_r22)), .y_in (rme_pkg::widen(s_r21)),
        .out_q (roll_c)
    );

    logic signed [15:0] r20_dly_reg [L];

    always_ff @(posedge aclk) begin
        if (en) begin
            r20_dly_reg[0] <= s_r20;
            for (int i = 1; i < L; i++) begin
                r20_dly_reg[i] <= r20_dly_reg[i-1];
            end
        end
    end

    // Gain compensation of the pitch cosine.
    logic [MW-1:0]         xmag;
    logic [PW-1:0]         prod_reg;
    logic signed [ZW-1:0]  yaw_z_reg, alt_z_reg, roll_z_reg;
    logic signed [XW-1:0]  nr20_reg;

    assign xmag = yaw_c.x[XW-1] ? '0 : yaw_c.x[MW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= PW'(xmag) * PW'(rme_pkg::GAIN_INV_Q30);
            yaw_z_reg  <= yaw_c.zero ? '0 : yaw_c.z;
            alt_z_reg  <= alt_c.zero ? '0 : alt_c.z;
            roll_z_reg <= roll_c.zero ? '0 : roll_c.z;
            nr20_reg   <= -rme_pkg::widen(r20_dly_reg[L-1]);
        end
    end

    logic [PW-1:0]        rounded;
    logic [MW-1:0]        cosp;
    logic                 sing;
    logic signed [ZW-1:0] yaw_sel, roll_sel;

    assign rounded  = prod_reg + (PW'(1) << 29);
    assign cosp     = rounded[PW-1:30];
    assign sing     = cosp < MW'({limit_reg, 14'b0});
    assign yaw_sel  = sing ? alt_z_reg : yaw_z_reg;
    assign roll_sel = sing ? '0 : roll_z_reg;

    // Second rank: pitch from the cosine and the negated r20.
    rme_cordic_chain #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk (aclk), .en (en),
        .x_in ({{(XW-MW){1'b0}}, cosp}), .y_in (nr20_reg),
        .out_q (pitch_c)
    );

    logic signed [ZW-1:0] yaw_dly_reg  [L];
    logic signed [ZW-1:0] roll_dly_reg [L];
    logic                 sing_dly_reg [L];

    always_ff @(posedge aclk) begin
        if (en) begin
            yaw_dly_reg[0]  <= yaw_sel;
            roll_dly_reg[0] <= roll_sel;
            sing_dly_reg[0] <= sing;
            for (int i = 1; i < L; i++) begin
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                sing_dly_reg[i] <= sing_dly_reg[i-1];
            end
        end
    end

    logic [15:0] roll_out_reg, pitch_out_reg, yaw_out_reg;
    logic        sing_out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            roll_out_reg  <= rme_pkg::to_q13(roll_dly_reg[L-1]);
            pitch_out_reg <= rme_pkg::to_q13(pitch_c.zero ? '0 : pitch_c.z);
            yaw_out_reg   <= rme_pkg::to_q13(yaw_dly_reg[L-1]);
            sing_out_reg  <= sing_dly_reg[L-1];
        end
    end

    assign m_roll_angle  = roll_out_reg;
    assign m_pitch_angle = pitch_out_reg;
    assign m_yaw_angle   = yaw_out_reg;
    assign m_singular    = sing_out_reg;

endmodule
